// ----- src/vtb_pkg.sv -----
package vtb_pkg;

    localparam int COORD_W     = 32;
    localparam int FRAC_BITS   = 16;
    localparam int CFG_W       = 64;
    localparam int CFG_ADDR_W  = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int S_DATA_W    = 96;
    localparam int M_DATA_W    = 288;
    localparam int PROD_W      = 2 * COORD_W;
    localparam int SUM_W       = PROD_W + 2;

    localparam logic [CFG_ADDR_W-1:0] REG_COL_X01 = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_COL_X23 = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_COL_Y01 = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_COL_Y23 = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_COL_Z01 = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_COL_Z23 = 3'd5;

    localparam logic [CFG_W-1:0] RST_COL_X01 = 64'h0000_0000_0001_0000;
    localparam logic [CFG_W-1:0] RST_COL_X23 = 64'h0;
    localparam logic [CFG_W-1:0] RST_COL_Y01 = 64'h0001_0000_0000_0000;
    localparam logic [CFG_W-1:0] RST_COL_Y23 = 64'h0;
    localparam logic [CFG_W-1:0] RST_COL_Z01 = 64'h0;
    localparam logic [CFG_W-1:0] RST_COL_Z23 = 64'h0000_0000_0001_0000;

    localparam logic signed [COORD_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] NEG_MAX = 32'sh8000_0000;

    typedef struct packed {
        logic [CFG_W-1:0] col_x01;
        logic [CFG_W-1:0] col_x23;
        logic [CFG_W-1:0] col_y01;
        logic [CFG_W-1:0] col_y23;
        logic [CFG_W-1:0] col_z01;
        logic [CFG_W-1:0] col_z23;
    } matrix_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      last;
    } vertex_t;

    typedef struct packed {
        logic valid;
    } queue_ctl_t;

endpackage

// ----- src/vtb_front.sv -----
module vtb_front #(
    parameter int DEPTH = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [vtb_pkg::S_DATA_W-1:0] s_tdata,  // in_x, in_y, in_z
    input  logic                         s_tlast,  // set_end
    input  logic                         pop,
    output vtb_pkg::queue_ctl_t          ctl,
    output vtb_pkg::vertex_t             head
);
    import vtb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    vertex_t                 entry_reg [DEPTH];
    logic    [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic    [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic    [CNT_W-1:0]     count_reg, count_next;
    logic                    push;
    logic                    do_pop;
    vertex_t                 beat;

    assign beat.x    = s_tdata[COORD_W-1:0];
    assign beat.y    = s_tdata[2*COORD_W-1:COORD_W];
    assign beat.z    = s_tdata[3*COORD_W-1:2*COORD_W];
    assign beat.last = s_tlast;

    assign s_tready = (count_reg != CNT_W'(DEPTH));
    assign push     = s_tvalid && s_tready;
    assign do_pop   = pop && (count_reg != '0);

    assign ctl.valid = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= beat;
        end
    end

endmodule

// ----- src/vtb_back.sv -----
module vtb_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  vtb_pkg::matrix_t             mat,
    input  vtb_pkg::queue_ctl_t          ctl,
    input  vtb_pkg::vertex_t             head,
    output logic                         pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // out_x, out_y, out_z, min_x, min_y, min_z, max_x, max_y, max_z
    output logic [vtb_pkg::M_DATA_W-1:0] m_tdata,
    output logic                         m_tlast   // final_bounds
);
    import vtb_pkg::*;

    logic                        adv;

    logic                        s1_valid_reg;
    logic                        s1_last_reg;
    logic signed [PROD_W-1:0]    prod_reg [3][3];
    logic signed [COORD_W-1:0]   trans_reg [3];

    logic                        s2_valid_reg;
    logic                        s2_last_reg;
    logic signed [COORD_W-1:0]   t_reg [3];
    logic signed [COORD_W-1:0]   t_next [3];

    logic signed [COORD_W-1:0]   lo_reg [3];
    logic signed [COORD_W-1:0]   hi_reg [3];
    logic signed [COORD_W-1:0]   lo_next [3];
    logic signed [COORD_W-1:0]   hi_next [3];

    logic                        m_valid_reg;
    logic                        m_last_reg;
    logic [M_DATA_W-1:0]         m_data_reg;

    logic signed [COORD_W-1:0]   coef [3][4];
    logic signed [COORD_W-1:0]   vin [3];

    assign coef[0][0] = mat.col_x01[COORD_W-1:0];
    assign coef[0][1] = mat.col_x01[CFG_W-1:COORD_W];
    assign coef[0][2] = mat.col_x23[COORD_W-1:0];
    assign coef[0][3] = mat.col_x23[CFG_W-1:COORD_W];
    assign coef[1][0] = mat.col_y01[COORD_W-1:0];
    assign coef[1][1] = mat.col_y01[CFG_W-1:COORD_W];
    assign coef[1][2] = mat.col_y23[COORD_W-1:0];
    assign coef[1][3] = mat.col_y23[CFG_W-1:COORD_W];
    assign coef[2][0] = mat.col_z01[COORD_W-1:0];
    assign coef[2][1] = mat.col_z01[CFG_W-1:COORD_W];
    assign coef[2][2] = mat.col_z23[COORD_W-1:0];
    assign coef[2][3] = mat.col_z23[CFG_W-1:COORD_W];

    assign vin[0] = head.x;
    assign vin[1] = head.y;
    assign vin[2] = head.z;

    assign adv      = !m_valid_reg || m_tready;
    assign pop      = adv;
    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = m_data_reg;

    // multiply stage
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_last_reg <= head.last;
            for (int c = 0; c < 3; c++) begin
                for (int r = 0; r < 3; r++) begin
                    prod_reg[c][r] <= vin[r] * coef[c][r];
                end
                trans_reg[c] <= coef[c][3];
            end
        end
    end

    // sum, floor and saturate
    always_comb begin
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] shr;
        for (int c = 0; c < 3; c++) begin
            sum = SUM_W'(prod_reg[c][0]) + SUM_W'(prod_reg[c][1])
                + SUM_W'(prod_reg[c][2])
                + {{(SUM_W-COORD_W-FRAC_BITS){trans_reg[c][COORD_W-1]}},
                   trans_reg[c], {FRAC_BITS{1'b0}}};
            shr = sum >>> FRAC_BITS;
            if (shr > SUM_W'(POS_MAX)) begin
                t_next[c] = POS_MAX;
            end else if (shr < SUM_W'(NEG_MAX)) begin
                t_next[c] = NEG_MAX;
            end else begin
                t_next[c] = shr[COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_last_reg <= s1_last_reg;
            for (int c = 0; c < 3; c++) begin
                t_reg[c] <= t_next[c];
            end
        end
    end

    // bounds
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            lo_next[c] = (t_reg[c] < lo_reg[c]) ? t_reg[c] : lo_reg[c];
            hi_next[c] = (t_reg[c] > hi_reg[c]) ? t_reg[c] : hi_reg[c];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            for (int c = 0; c < 3; c++) begin
                lo_reg[c] <= POS_MAX;
                hi_reg[c] <= NEG_MAX;
            end
        end else if (adv) begin
            s1_valid_reg <= ctl.valid;
            s2_valid_reg <= s1_valid_reg;
            m_valid_reg  <= s2_valid_reg;
            if (s2_valid_reg) begin
                for (int c = 0; c < 3; c++) begin
                    lo_reg[c] <= s2_last_reg ? POS_MAX : lo_next[c];
                    hi_reg[c] <= s2_last_reg ? NEG_MAX : hi_next[c];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_last_reg <= s2_last_reg;
            m_data_reg <= {hi_next[2], hi_next[1], hi_next[0],
                           lo_next[2], lo_next[1], lo_next[0],
                           t_reg[2], t_reg[1], t_reg[0]};
        end
    end

endmodule

// ----- src/vertex_transform_with_bounds_unit.sv -----
// Channel  Ports        tdata (low bit up)                        tlast
// s_       in beats     in_x, in_y, in_z (96 bits)                set_end
// m_       result beats out_x..z, min_x..z, max_x..z (288 bits)   final_bounds
// cfg_     reg writes   cfg_addr 0..5 selects the column word, cfg_wdata 64 bits
//
// One beat per cycle sustained while the m_ side is not stalled; a beat passes, in order:
// queue write, one 32x32 multiply stage, sum/floor/saturate, bounds and output.
// The input queue holds QUEUE_DEPTH beats, so s_tready falls only when it is full.
// Reset (aresetn low, synchronous) restores the identity matrix, empties the queue
// and returns the bounds to their start values; a stalled m_ side freezes the back.
module vertex_transform_with_bounds_unit #(
    parameter int QUEUE_DEPTH = vtb_pkg::QUEUE_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [vtb_pkg::S_DATA_W-1:0]   s_tdata,   // in_x, in_y, in_z
    input  logic                           s_tlast,   // set_end
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_x, out_y, out_z, min_x, min_y, min_z, max_x, max_y, max_z
    output logic [vtb_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                           m_tlast,   // final_bounds
    input  logic                           cfg_we,
    input  logic [vtb_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [vtb_pkg::CFG_W-1:0]      cfg_wdata
);
    import vtb_pkg::*;

    matrix_t    mat_reg;
    queue_ctl_t ctl;
    vertex_t    head;
    logic       pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mat_reg.col_x01 <= RST_COL_X01;
            mat_reg.col_x23 <= RST_COL_X23;
            mat_reg.col_y01 <= RST_COL_Y01;
            mat_reg.col_y23 <= RST_COL_Y23;
            mat_reg.col_z01 <= RST_COL_Z01;
            mat_reg.col_z23 <= RST_COL_Z23;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_COL_X01: mat_reg.col_x01 <= cfg_wdata;
                REG_COL_X23: mat_reg.col_x23 <= cfg_wdata;
                REG_COL_Y01: mat_reg.col_y01 <= cfg_wdata;
                REG_COL_Y23: mat_reg.col_y23 <= cfg_wdata;
                REG_COL_Z01: mat_reg.col_z01 <= cfg_wdata;
                REG_COL_Z23: mat_reg.col_z23 <= cfg_wdata;
                default: ;
            endcase
        end
    end

    vtb_front #(
        .DEPTH(QUEUE_DEPTH)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .pop     (pop),
        .ctl     (ctl),
        .head    (head)
    );

    vtb_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .mat     (mat_reg),
        .ctl     (ctl),
        .head    (head),
        .pop     (pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

endmodule

// ----- bench/transform_checker.sv -----
module transform_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [vtb_pkg::S_DATA_W-1:0]   s_tdata,   // in_x, in_y, in_z
    input  logic                           s_tlast,   // set_end
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // out_x, out_y, out_z, min_x, min_y, min_z, max_x, max_y, max_z
    input  logic [vtb_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                           m_tlast,   // final_bounds
    input  logic                           cfg_we,
    input  logic [vtb_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [vtb_pkg::CFG_W-1:0]      cfg_wdata,
    output int                             mismatches,
    output int                             outstanding
);
    import vtb_pkg::*;

    localparam logic signed [SUM_W-1:0] SAT_HI = POS_MAX;
    localparam logic signed [SUM_W-1:0] SAT_LO = NEG_MAX;

    typedef struct packed {
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic [COORD_W-1:0] out_z;
        logic [COORD_W-1:0] min_x;
        logic [COORD_W-1:0] min_y;
        logic [COORD_W-1:0] min_z;
        logic [COORD_W-1:0] max_x;
        logic [COORD_W-1:0] max_y;
        logic [COORD_W-1:0] max_z;
        logic               final_bounds;
    } xform_t;

    matrix_t                   mat;
    logic signed [COORD_W-1:0] low_b  [3];
    logic signed [COORD_W-1:0] high_b [3];
    xform_t                    due_xforms [$];

    function automatic logic signed [COORD_W-1:0] project_column(
        input logic signed [COORD_W-1:0] x,
        input logic signed [COORD_W-1:0] y,
        input logic signed [COORD_W-1:0] z,
        input logic [CFG_W-1:0]          r01,
        input logic [CFG_W-1:0]          r23
    );
        logic signed [COORD_W-1:0] m0, m1, m2, m3;
        logic signed [SUM_W-1:0]   acc;
        logic signed [SUM_W-1:0]   q;
        m0  = r01[COORD_W-1:0];
        m1  = r01[CFG_W-1:COORD_W];
        m2  = r23[COORD_W-1:0];
        m3  = r23[CFG_W-1:COORD_W];
        acc = x * m0 + y * m1 + z * m2
            + $signed({{(SUM_W-COORD_W-FRAC_BITS){m3[COORD_W-1]}}, m3, {FRAC_BITS{1'b0}}});
        q   = acc >>> FRAC_BITS;
        if (q > SAT_HI) begin
            return POS_MAX;
        end
        if (q < SAT_LO) begin
            return NEG_MAX;
        end
        return q[COORD_W-1:0];
    endfunction

    function automatic void restart_bounds();
        for (int i = 0; i < 3; i++) begin
            low_b[i]  = POS_MAX;
            high_b[i] = NEG_MAX;
        end
    endfunction

    function automatic xform_t transform_vertex(input vertex_t v);
        logic signed [COORD_W-1:0] t [3];
        xform_t r;
        t[0] = project_column(v.x, v.y, v.z, mat.col_x01, mat.col_x23);
        t[1] = project_column(v.x, v.y, v.z, mat.col_y01, mat.col_y23);
        t[2] = project_column(v.x, v.y, v.z, mat.col_z01, mat.col_z23);
        for (int i = 0; i < 3; i++) begin
            if (t[i] < low_b[i]) low_b[i] = t[i];
            if (t[i] > high_b[i]) high_b[i] = t[i];
        end
        r.out_x        = t[0];
        r.out_y        = t[1];
        r.out_z        = t[2];
        r.min_x        = low_b[0];
        r.min_y        = low_b[1];
        r.min_z        = low_b[2];
        r.max_x        = high_b[0];
        r.max_y        = high_b[1];
        r.max_z        = high_b[2];
        r.final_bounds = v.last;
        if (v.last) restart_bounds();
        return r;
    endfunction

    task automatic check_field(input string name, input logic [COORD_W-1:0] want,
                               input logic [COORD_W-1:0] got);
        if (got !== want) begin
            if (mismatches < 10) begin
                $display("mismatch on %s: expected %h, got %h", name, want, got);
            end
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : watch
        vertex_t v;
        xform_t  want;
        xform_t  got;
        if (!aresetn) begin
            mat = {RST_COL_X01, RST_COL_X23, RST_COL_Y01, RST_COL_Y23, RST_COL_Z01,
                   RST_COL_Z23};
            restart_bounds();
            due_xforms.delete();
            mismatches = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_COL_X01: mat.col_x01 = cfg_wdata;
                    REG_COL_X23: mat.col_x23 = cfg_wdata;
                    REG_COL_Y01: mat.col_y01 = cfg_wdata;
                    REG_COL_Y23: mat.col_y23 = cfg_wdata;
                    REG_COL_Z01: mat.col_z01 = cfg_wdata;
                    REG_COL_Z23: mat.col_z23 = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                v.x    = s_tdata[0*COORD_W +: COORD_W];
                v.y    = s_tdata[1*COORD_W +: COORD_W];
                v.z    = s_tdata[2*COORD_W +: COORD_W];
                v.last = s_tlast;
                due_xforms.push_back(transform_vertex(v));
            end
            if (m_tvalid && m_tready) begin
                got.out_x        = m_tdata[0*COORD_W +: COORD_W];
                got.out_y        = m_tdata[1*COORD_W +: COORD_W];
                got.out_z        = m_tdata[2*COORD_W +: COORD_W];
                got.min_x        = m_tdata[3*COORD_W +: COORD_W];
                got.min_y        = m_tdata[4*COORD_W +: COORD_W];
                got.min_z        = m_tdata[5*COORD_W +: COORD_W];
                got.max_x        = m_tdata[6*COORD_W +: COORD_W];
                got.max_y        = m_tdata[7*COORD_W +: COORD_W];
                got.max_z        = m_tdata[8*COORD_W +: COORD_W];
                got.final_bounds = m_tlast;
                if (due_xforms.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("result beat with nothing expected: %h last %b",
                                 m_tdata, m_tlast);
                    end
                    mismatches++;
                end else begin
                    want = due_xforms.pop_front();
                    check_field("out_x", want.out_x, got.out_x);
                    check_field("out_y", want.out_y, got.out_y);
                    check_field("out_z", want.out_z, got.out_z);
                    check_field("min_x", want.min_x, got.min_x);
                    check_field("min_y", want.min_y, got.min_y);
                    check_field("min_z", want.min_z, got.min_z);
                    check_field("max_x", want.max_x, got.max_x);
                    check_field("max_y", want.max_y, got.max_y);
                    check_field("max_z", want.max_z, got.max_z);
                    check_field("final_bounds", {31'b0, want.final_bounds},
                                {31'b0, got.final_bounds});
                end
            end
        end
        outstanding = due_xforms.size();
    end

endmodule

// ----- bench/testbench.sv -----
module testbench;

    import vtb_pkg::*;

    localparam int LIMIT = 200000;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_7 = 3'd7;

    typedef enum int {ENTRY_MILD, ENTRY_FULL, ENTRY_EDGE} entry_kind_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;
    int                    mismatches;
    int                    outstanding;
    int                    cycles    = 0;
    int                    sink_hold = 0;
    bit                    steady    = 0;

    vertex_transform_with_bounds_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    transform_checker i_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial aclk = 1'b0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return POS_MAX;
            1: return NEG_MAX;
            2: return '0;
            3, 4, 5: return $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] rand_entry(input entry_kind_t kind);
        case (kind)
            ENTRY_MILD: return $urandom_range(0, 32'h0006_0000) - 32'h0003_0000;
            ENTRY_FULL: return $urandom;
            default: begin
                case ($urandom_range(0, 5))
                    0: return POS_MAX;
                    1: return NEG_MAX;
                    2: return '0;
                    3: return 32'h0001_0000;
                    4: return 32'hFFFF_0000;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    function automatic matrix_t rand_matrix(input entry_kind_t kind);
        matrix_t m;
        m.col_x01 = {rand_entry(kind), rand_entry(kind)};
        m.col_x23 = {rand_entry(kind), rand_entry(kind)};
        m.col_y01 = {rand_entry(kind), rand_entry(kind)};
        m.col_y23 = {rand_entry(kind), rand_entry(kind)};
        m.col_z01 = {rand_entry(kind), rand_entry(kind)};
        m.col_z23 = {rand_entry(kind), rand_entry(kind)};
        return m;
    endfunction

    task automatic put_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(negedge aclk);
    endtask

    task automatic load_matrix(input matrix_t m, input bit poke_spare);
        put_reg(REG_COL_X01, m.col_x01);
        put_reg(REG_COL_X23, m.col_x23);
        put_reg(REG_COL_Y01, m.col_y01);
        put_reg(REG_COL_Y23, m.col_y23);
        put_reg(REG_COL_Z01, m.col_z01);
        put_reg(REG_COL_Z23, m.col_z23);
        if (poke_spare) begin
            put_reg(REG_SPARE_6, {$urandom, $urandom});
            put_reg(REG_SPARE_7, {$urandom, $urandom});
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send_vertex(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                               input logic [COORD_W-1:0] z, input logic last);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // drop valid and hold until every result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
    endtask

    task automatic run_sets(input int count);
        int sent;
        int len;
        sent = 0;
        while (sent < count) begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
            for (int i = 0; i < len; i++) begin
                send_vertex(rand_coord(), rand_coord(), rand_coord(), i == len - 1);
            end
            sent += len;
        end
    endtask

    initial begin : sink
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (sink_hold > 0) begin
                stall     = sink_hold;
                sink_hold = 0;
            end else begin
                stall = steady ? 0 : $urandom_range(0, 3);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        matrix_t m;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // identity after reset
        send_vertex('0, '0, '0, 1'b0);
        send_vertex(POS_MAX, NEG_MAX, 32'h0000_0001, 1'b0);
        send_vertex(NEG_MAX, POS_MAX, 32'hFFFF_FFFF, 1'b0);
        send_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_vertex(32'h0000_3039, 32'hFFFF_FFFB, 32'h0000_0007, 1'b1);

        // saturation both ways, fractional floor, translation
        drain();
        m.col_x01 = {POS_MAX, POS_MAX};
        m.col_x23 = {POS_MAX, POS_MAX};
        m.col_y01 = {NEG_MAX, NEG_MAX};
        m.col_y23 = {NEG_MAX, NEG_MAX};
        m.col_z01 = {32'hFFFF_8000, 32'h0002_0000};
        m.col_z23 = {32'h0003_0000, 32'h0001_0000};
        load_matrix(m, 1'b1);
        send_vertex(POS_MAX, POS_MAX, POS_MAX, 1'b0);
        send_vertex(NEG_MAX, NEG_MAX, NEG_MAX, 1'b0);
        send_vertex('0, '0, '0, 1'b0);
        send_vertex(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_8000, 1'b1);
        send_vertex(32'h0001_0000, 32'hFFFE_0000, 32'h0000_0001, 1'b1);
        send_vertex(NEG_MAX, POS_MAX, '0, 1'b1);

        drain();
        load_matrix({RST_COL_X01, RST_COL_X23, RST_COL_Y01, RST_COL_Y23, RST_COL_Z01,
                     RST_COL_Z23}, 1'b0);
        run_sets(20);

        for (int p = 0; p < 7; p++) begin
            drain();
            case (p)
                0: load_matrix(rand_matrix(ENTRY_MILD), 1'b0);
                1: load_matrix(rand_matrix(ENTRY_MILD), 1'b1);
                2: load_matrix({12{POS_MAX}}, 1'b0);
                3: load_matrix(rand_matrix(ENTRY_FULL), 1'b0);
                4: load_matrix({12{NEG_MAX}}, 1'b0);
                5: load_matrix('0, 1'b0);
                default: load_matrix(rand_matrix(ENTRY_EDGE), 1'b1);
            endcase
            case (p)
                1: begin
                    // hold the sink off while the source keeps pushing
                    sink_hold = 120;
                    steady    = 1'b1;
                    run_sets(40);
                    steady    = 1'b0;
                    run_sets(110);
                end
                3: begin
                    run_sets(75);
                    drain();
                    run_sets(75);
                end
                4: begin
                    steady = 1'b1;
                    run_sets(150);
                    steady = 1'b0;
                end
                5: run_sets(80);
                default: run_sets(150);
            endcase
        end

        drain();
        repeat (16) @(negedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

// ----- vertex_transform_with_bounds_unit.f -----
src/vtb_pkg.sv
src/vtb_front.sv
src/vtb_back.sv
src/vertex_transform_with_bounds_unit.sv
bench/transform_checker.sv
bench/testbench.sv
